>>> rtl/vrr_pkg.sv
// Shared types, widths and helpers for the reflect/refract pipeline.
package vrr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW = 18;              // vector component width
  localparam int RW = 19;              // ratio width
  localparam int TW = FRAC_BITS + 1;   // tangential part once known below 1.0
  localparam int FW = CW + 5;          // reflected component width
  localparam int DW = 2 * FRAC_BITS + 1; // discriminant width
  localparam int SW = FRAC_BITS + 2;   // root width inside the square root
  localparam int XW = 2 * SW;          // remainder width
  localparam int SQ_STEPS = SW / 2;    // square root stages, two bits each

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [TW-1:0] tan_t;
  typedef logic signed [FW-1:0] refl_t;

  // Payload that rides alongside the square root
  typedef struct packed {
    logic            cmd;
    logic            tir;
    logic            dneg;
    comp_t [2:0]     n;
    tan_t  [2:0]     t;
    refl_t [2:0]     refl;
  } side_t;

  // One digit of the square root: try to add 2^k to the root
  function automatic logic [XW+SW-1:0] sqrt_step(input logic [XW-1:0] rem,
                                                 input logic [SW-1:0] root,
                                                 input int k);
    logic [XW-1:0] term;
    logic [XW-1:0] rem_o;
    logic [SW-1:0] root_o;
    term   = (XW'(root) << (k + 1)) + (XW'(1) << (2 * k));
    rem_o  = rem;
    root_o = root;
    if (rem >= term) begin
      rem_o  = rem - term;
      root_o = root | (SW'(1) << k);
    end
    return {rem_o, root_o};
  endfunction

  // Clamp to the output component range
  function automatic comp_t sat_comp(input logic signed [FW:0] x);
    logic signed [FW:0] hi;
    logic signed [FW:0] lo;
    hi = (FW+1)'((1 <<< (CW - 1)) - 1);
    lo = -(FW+1)'(1 <<< (CW - 1));
    if (x > hi) return comp_t'(hi);
    if (x < lo) return comp_t'(lo);
    return comp_t'(x);
  endfunction

endpackage

>>> rtl/vector_reflect_refract.sv
// Top level: mirror reflection or Snell refraction of a fixed-point ray direction.
//
//  channel | handshake              | beat contents
//  input   | in_valid / in_ready    | command, vx vy vz, nx ny nz, vdotn, ratio
//  output  | out_valid / out_ready  | rx ry rz, total_reflect
//
// The pipeline has five arithmetic stages, nine square root stages
// (two root bits each), a multiply stage and the output register.
// One beat per cycle while out_ready is high; every stage holds its own
// valid and only stalls when the stage after it is full and stalled, so
// bubbles are squeezed out. Reset clears the valid bits only.
module vector_reflect_refract
  import vrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic signed [17:0] vx,
  input  logic signed [17:0] vy,
  input  logic signed [17:0] vz,
  input  logic signed [17:0] nx,
  input  logic signed [17:0] ny,
  input  logic signed [17:0] nz,
  input  logic signed [17:0] vdotn,
  input  logic [18:0]        ratio,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [17:0] rx,
  output logic signed [17:0] ry,
  output logic signed [17:0] rz,
  output logic              total_reflect
);

  localparam int PW = 2 * CW;          // n * vdotn
  localparam int UW = CW + 3;          // v - n*vdotn
  localparam int QW = UW + RW + 1;     // ratio * u
  localparam int GW = QW - FRAC_BITS;  // unreduced tangential part
  localparam int LW = 2 * TW;          // square and sum width
  localparam int MW = CW + SW + 1;     // n * root

  logic vld1, vld2, vld3, vld4, vld5, vld6, vld7;
  logic a1, a2, a3, a4, a5, a6, a7;
  logic sq_in_ready, sq_out_valid;

  // stage 1 registers
  logic             cmd1, dneg1;
  comp_t [2:0]      v1, n1;
  logic [RW-1:0]    ratio1;
  logic signed [PW-1:0] p1 [3];
  // stage 2
  logic             cmd2, dneg2;
  comp_t [2:0]      n2;
  logic [RW-1:0]    ratio2;
  logic signed [UW-1:0] u2 [3];
  refl_t [2:0]      refl2;
  // stage 3
  logic             cmd3, dneg3;
  comp_t [2:0]      n3;
  refl_t [2:0]      refl3;
  logic signed [QW-1:0] q3 [3];
  // stage 4
  logic             cmd4, dneg4, big4;
  comp_t [2:0]      n4;
  refl_t [2:0]      refl4;
  tan_t  [2:0]      t4;
  logic signed [LW-1:0] sq4 [3];
  // stage 5
  logic [DW-1:0]    disc5;
  side_t            side5;
  // square root result
  logic [SW-1:0]    root_q;
  side_t            side_q;
  // stage 6
  side_t            side6;
  logic signed [MW-1:0] m6 [3];

  // ready chain, back to front
  assign a7 = !vld7 || out_ready;
  assign a6 = !vld6 || a7;
  assign a5 = !vld5 || sq_in_ready;
  assign a4 = !vld4 || a5;
  assign a3 = !vld3 || a4;
  assign a2 = !vld2 || a3;
  assign a1 = !vld1 || a2;
  assign in_ready = a1;
  assign out_valid = vld7;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0; vld2 <= 1'b0; vld3 <= 1'b0; vld4 <= 1'b0;
      vld5 <= 1'b0; vld6 <= 1'b0; vld7 <= 1'b0;
    end else begin
      if (a1) vld1 <= in_valid;
      if (a2) vld2 <= vld1;
      if (a3) vld3 <= vld2;
      if (a4) vld4 <= vld3;
      if (a5) vld5 <= vld4;
      if (a6) vld6 <= sq_out_valid;
      if (a7) vld7 <= vld6;
    end
  end

  // stage 1: n * vdotn
  always_ff @(posedge clk) begin
    if (a1) begin
      cmd1   <= command;
      dneg1  <= vdotn[CW-1];
      ratio1 <= ratio;
      v1     <= {vz, vy, vx};
      n1     <= {nz, ny, nx};
      p1[0]  <= nx * vdotn;
      p1[1]  <= ny * vdotn;
      p1[2]  <= nz * vdotn;
    end
  end

  // stage 2: remove normal part, build reflection
  always_ff @(posedge clk) begin
    if (a2) begin
      cmd2   <= cmd1;
      dneg2  <= dneg1;
      ratio2 <= ratio1;
      n2     <= n1;
      for (int i = 0; i < 3; i++) begin
        u2[i]    <= UW'($signed(v1[i])) - UW'(p1[i] >>> FRAC_BITS);
        refl2[i] <= FW'($signed(v1[i])) - FW'(p1[i] >>> (FRAC_BITS - 1));
      end
    end
  end

  // stage 3: scale by ratio
  always_ff @(posedge clk) begin
    if (a3) begin
      cmd3  <= cmd2;
      dneg3 <= dneg2;
      n3    <= n2;
      refl3 <= refl2;
      for (int i = 0; i < 3; i++) begin
        q3[i] <= QW'($signed({1'b0, ratio2}) * u2[i]);
      end
    end
  end

  // stage 4: reduce, range check, square
  logic signed [GW-1:0] g4 [3];
  logic                 big4_next;
  always_comb begin
    big4_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      g4[i] = GW'(q3[i] >>> FRAC_BITS);
      if (g4[i] >= GW'(1 <<< FRAC_BITS) || g4[i] <= -GW'(1 <<< FRAC_BITS))
        big4_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a4) begin
      cmd4  <= cmd3;
      dneg4 <= dneg3;
      n4    <= n3;
      refl4 <= refl3;
      big4  <= big4_next;
      for (int i = 0; i < 3; i++) begin
        t4[i]  <= TW'(g4[i]);
        sq4[i] <= TW'(g4[i]) * TW'(g4[i]);
      end
    end
  end

  // stage 5: discriminant and fallback decision
  logic signed [LW+1:0] disc_w;
  logic                 tir5_next;
  always_comb begin
    disc_w    = (LW+2)'(1) <<< (2 * FRAC_BITS);
    disc_w    = disc_w - (LW+2)'(sq4[0]) - (LW+2)'(sq4[1]) - (LW+2)'(sq4[2]);
    tir5_next = cmd4 && (big4 || disc_w <= (LW+2)'(0));
  end

  always_ff @(posedge clk) begin
    if (a5) begin
      disc5       <= (cmd4 && !tir5_next) ? DW'(disc_w) : '0;
      side5.cmd   <= cmd4;
      side5.tir   <= tir5_next;
      side5.dneg  <= dneg4;
      side5.n     <= n4;
      side5.t     <= t4;
      side5.refl  <= refl4;
    end
  end

  vrr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld5),
    .in_ready  (sq_in_ready),
    .disc      (disc5),
    .side_in   (side5),
    .out_valid (sq_out_valid),
    .out_ready (a6),
    .root      (root_q),
    .side_out  (side_q)
  );

  // stage 6: n * sqrt(disc)
  always_ff @(posedge clk) begin
    if (a6) begin
      side6 <= side_q;
      for (int i = 0; i < 3; i++) begin
        m6[i] <= MW'($signed(side_q.n[i]) * $signed({1'b0, root_q}));
      end
    end
  end

  // stage 7: combine, select, saturate
  logic signed [FW:0] r7 [3];
  logic signed [FW:0] np7;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      np7 = (FW+1)'(m6[i] >>> FRAC_BITS);
      if (side6.dneg) np7 = -np7;
      if (side6.cmd && !side6.tir)
        r7[i] = (FW+1)'($signed(side6.t[i])) + np7;
      else
        r7[i] = (FW+1)'($signed(side6.refl[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (a7) begin
      rx            <= sat_comp(r7[0]);
      ry            <= sat_comp(r7[1]);
      rz            <= sat_comp(r7[2]);
      total_reflect <= side6.tir;
    end
  end

  // a free output side lets every stage move
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready) else $error("input stalled with output free");

  // reflect beats never flag fallback
  a_reflect_no_tir: assert property (@(posedge clk) disable iff (rst)
    vld5 && !side5.cmd |-> !side5.tir) else $error("tir on reflect beat");

  // fallback beats feed a zero discriminant into the root
  a_tir_zero_disc: assert property (@(posedge clk) disable iff (rst)
    vld5 && side5.tir |-> disc5 == '0) else $error("tir with nonzero disc");

  // a stalled output beat keeps its value
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(ry)
      && $stable(rz) && $stable(total_reflect))
    else $error("output hold");

endmodule

>>> rtl/vrr_sqrt.sv
// Pipelined integer square root, two root bits per stage, with sidecar payload.
module vrr_sqrt
  import vrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DW-1:0]         disc,
  input  side_t                 side_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SW-1:0]         root,
  output side_t                 side_out
);

  logic              vld  [SQ_STEPS];
  logic              adv  [SQ_STEPS+1];
  logic [XW-1:0]     rem  [SQ_STEPS];
  logic [SW-1:0]     rt   [SQ_STEPS];
  side_t             sd   [SQ_STEPS];

  assign adv[SQ_STEPS] = out_ready;

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stage
    logic [XW-1:0]    rem_i;
    logic [SW-1:0]    rt_i;
    logic [XW+SW-1:0] st_a;
    logic [XW+SW-1:0] st_b;
    logic             vld_i;
    side_t            sd_i;

    // stage input: module port or previous stage
    if (s == 0) begin : g_first
      assign rem_i = XW'(disc);
      assign rt_i  = '0;
      assign vld_i = in_valid;
      assign sd_i  = side_in;
    end else begin : g_next
      assign rem_i = rem[s-1];
      assign rt_i  = rt[s-1];
      assign vld_i = vld[s-1];
      assign sd_i  = sd[s-1];
    end

    assign adv[s] = !vld[s] || adv[s+1];
    assign st_a   = sqrt_step(rem_i, rt_i, SW - 1 - 2 * s);
    assign st_b   = sqrt_step(st_a[XW+SW-1:SW], st_a[SW-1:0], SW - 2 - 2 * s);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv[s]) begin
        vld[s] <= vld_i;
      end
      if (adv[s]) begin
        rem[s] <= st_b[XW+SW-1:SW];
        rt[s]  <= st_b[SW-1:0];
        sd[s]  <= sd_i;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[SQ_STEPS-1];
  assign root      = rt[SQ_STEPS-1];
  assign side_out  = sd[SQ_STEPS-1];

endmodule
